// ===== rtl/nps_pkg.sv =====
// ----------------------------------------------------------------------------
// nps_pkg
// Types and constants shared by the nearest pose search unit.
// ----------------------------------------------------------------------------
`default_nettype none
package nps_pkg;
    localparam int unsigned ROUTE_DEPTH_DEF = 1024;
    localparam logic [18:0] PI_Q     = 19'd205887;
    localparam logic [19:0] TWO_PI_Q = 20'd411775;
    localparam logic [31:0] TALLY_MAX = 32'hFFFF_FFFF;
    localparam logic [31:0] THRESH_RESET = 32'd32768;

    localparam logic [1:0] ADDR_THRESH = 2'd0;

    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_QUERY  = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;
    localparam logic [1:0] OP_RSVD   = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_BAD   = 2'd3;

    localparam int unsigned NUM_TALLY = 10;
    localparam logic [3:0] SEL_MAX = 4'd9;
    localparam int unsigned POSE_W = 115;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] coord_z;
        logic [18:0]        heading;
        logic [3:0]         tally_select;
    } t_in;

    typedef struct packed {
        logic [9:0]  nearest_index;
        logic [35:0] weighted_distance;
        logic [34:0] absolute_distance;
        logic [31:0] tally_value;
        logic [1:0]  status;
    } t_out;
endpackage
`default_nettype wire

// ===== rtl/nps_ram.sv =====
// ----------------------------------------------------------------------------
// nps_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module nps_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_addr,
    input  wire [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

// ===== rtl/nps_isqrt.sv =====
// ----------------------------------------------------------------------------
// nps_isqrt
// Pipelined floor square root of a 66-bit value, one result bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none
module nps_isqrt #(
    parameter int unsigned TAG_W = 8
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    input  wire [65:0]       i_rad,
    input  wire [TAG_W-1:0]  i_tag,
    output logic             o_valid,
    output logic [32:0]      o_root,
    output logic [TAG_W-1:0] o_tag
);
    localparam int unsigned STAGES = 33;

    // Restoring digit recurrence: remainder and root shift two radicand bits a stage.
    logic [STAGES:1]       r_vld;
    logic [65:0]           r_rad [1:STAGES];
    logic [32:0]           r_rem [1:STAGES];
    logic [32:0]           r_root [1:STAGES];
    logic [TAG_W-1:0]      r_tag [1:STAGES];

    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        logic             w_vin;
        logic [65:0]      w_rad;
        logic [32:0]      w_rem;
        logic [32:0]      w_rt;
        logic [TAG_W-1:0] w_tin;
        logic [34:0]      w_trial;
        logic [34:0]      w_sub;
        logic [34:0]      w_cur;
        if (s == 0) begin : g_head
            assign w_vin = i_valid;
            assign w_rad = i_rad;
            assign w_rem = '0;
            assign w_rt  = '0;
            assign w_tin = i_tag;
        end else begin : g_body
            assign w_vin = r_vld[s];
            assign w_rad = r_rad[s];
            assign w_rem = r_rem[s];
            assign w_rt  = r_root[s];
            assign w_tin = r_tag[s];
        end
        assign w_cur   = {w_rem, w_rad[65:64]};
        assign w_trial = {w_rt, 2'b01};
        assign w_sub   = w_cur - w_trial;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s+1] <= 1'b0;
            end else begin
                r_vld[s+1] <= w_vin;
            end
            r_rad[s+1] <= {w_rad[63:0], 2'b00};
            r_tag[s+1] <= w_tin;
            if (w_cur >= w_trial) begin
                r_rem[s+1]  <= w_sub[32:0];
                r_root[s+1] <= {w_rt[31:0], 1'b1};
            end else begin
                r_rem[s+1]  <= w_cur[32:0];
                r_root[s+1] <= {w_rt[31:0], 1'b0};
            end
        end
    end

    assign o_valid = r_vld[STAGES];
    assign o_root  = r_root[STAGES];
    assign o_tag   = r_tag[STAGES];
endmodule
`default_nettype wire

// ===== rtl/nearest_pose_search_unit.sv =====
// ----------------------------------------------------------------------------
// nearest_pose_search_unit
// Route pose store with a weighted nearest-neighbour scan and exceed tallies.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake        Payload
// in       input      i_valid/o_ready  nps_pkg::t_in
// out      output     o_valid/i_ready  nps_pkg::t_out
// cfg      input      APB write/read   threshold_step at address 0
//
// An append, a tally read, an empty-store query or an unknown operation loads
// the output register at the accepting edge, so its result is offered in the
// next cycle.
// A query streams the stored entries from the route RAM one per cycle through
// the RAM read, difference, square, sum, 33-stage square root and compare
// pipeline, and the best entry is loaded into the output register once the
// last comparison is done.
// Reset clears the fill count and the tallies; the RAM itself is not cleared.
// One beat is handled at a time: the input is held off during a scan and while a
// result waits in the output register, and it reopens the cycle after that
// result is taken, or after a query once the state is back from S_OUT to S_IDLE.
// ----------------------------------------------------------------------------
`default_nettype none
module nearest_pose_search_unit #(
    parameter int unsigned ROUTE_DEPTH = nps_pkg::ROUTE_DEPTH_DEF
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_valid,
    output logic          o_ready,
    input  nps_pkg::t_in  i_data,
    output logic          o_valid,
    input  wire           i_ready,
    output nps_pkg::t_out o_data,
    input  wire           psel,
    input  wire           penable,
    input  wire           pwrite,
    input  wire [1:0]     paddr,
    input  wire [31:0]    pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    import nps_pkg::*;

    localparam int unsigned AW = $clog2(ROUTE_DEPTH);
    localparam int unsigned LW = $clog2(ROUTE_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_DONE = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic [31:0]   r_thresh;
    logic [LW-1:0] r_len;
    logic [31:0]   r_tally [NUM_TALLY];
    t_in           r_req;
    logic [AW-1:0] r_issue;      // next address to read during a scan
    logic [LW-1:0] r_issued;
    logic [LW-1:0] r_seen;       // results compared so far
    logic          r_rd_vld;
    logic [AW-1:0] r_rd_idx;
    logic [9:0]    r_best_idx;
    logic [35:0]   r_best_w;
    logic [34:0]   r_best_a;
    logic          r_out_vld;
    logic          n_out_vld;
    t_out          r_out;
    t_out          n_out;

    // APB: configuration must be written only while idle; the block does not enforce it.
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_THRESH) ? r_thresh : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= THRESH_RESET;
        end else if (psel && penable && pwrite && paddr == ADDR_THRESH) begin
            r_thresh <= pwdata;
        end
    end

    assign o_ready = (r_state == S_IDLE) && !r_out_vld;
    wire w_acc = i_valid && o_ready;

    // The RAM port is shared between the append write and the scan reads.
    logic [AW-1:0]     w_addr;
    logic              w_we;
    logic [POSE_W-1:0] w_rdata;
    assign w_we   = w_acc && i_data.operation == OP_APPEND && r_len < LW'(ROUTE_DEPTH);
    assign w_addr = w_we ? r_len[AW-1:0] : r_issue;

    nps_ram #(.WIDTH(POSE_W), .DEPTH(ROUTE_DEPTH)) u_store (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_addr (w_addr),
        .i_wdata({i_data.coord_x, i_data.coord_y, i_data.coord_z, i_data.heading}),
        .o_rdata(w_rdata)
    );

    wire w_issue = (r_state == S_SCAN) && (r_issued < r_len);

    // Stage 1: absolute differences and the heading term.
    logic signed [31:0] w_sx, w_sy, w_sz;
    logic [18:0]        w_sh;
    assign {w_sx, w_sy, w_sz, w_sh} = w_rdata;

    function automatic logic [31:0] f_absdiff(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
        logic signed [32:0] d;
        d = 33'(a) - 33'(b);
        f_absdiff = d[32] ? 32'(-d) : d[31:0];
    endfunction

    logic [31:0] r_dx, r_dy, r_dz;
    logic [20:0] r_hd;
    logic        r_s1_vld;
    logic [AW-1:0] r_s1_idx;
    logic [19:0] w_ha, w_hb;
    always_comb begin
        w_ha = {1'b0, r_req.heading};
        w_hb = {1'b0, w_sh};
        if ((r_req.heading > PI_Q) != (w_sh > PI_Q)) begin
            if (!(r_req.heading > PI_Q)) w_ha = w_ha + TWO_PI_Q;
            if (!(w_sh > PI_Q))          w_hb = w_hb + TWO_PI_Q;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dx <= f_absdiff(w_sx, r_req.coord_x);
        r_dy <= f_absdiff(w_sy, r_req.coord_y);
        r_dz <= f_absdiff(w_sz, r_req.coord_z);
        r_hd <= {(w_ha > w_hb) ? w_ha - w_hb : w_hb - w_ha, 1'b0};
        r_s1_idx <= r_rd_idx;
    end

    // Stage 2: squares; stage 3: sum.
    logic [63:0] r_qx, r_qy, r_qz;
    logic [20:0] r_hd2, r_hd3;
    logic [AW-1:0] r_s2_idx, r_s3_idx;
    logic        r_s2_vld, r_s3_vld;
    logic [65:0] r_sum;
    always_ff @(posedge i_clk) begin
        r_qx <= r_dx * r_dx;
        r_qy <= r_dy * r_dy;
        r_qz <= r_dz * r_dz;
        r_hd2 <= r_hd;
        r_s2_idx <= r_s1_idx;
        r_sum <= 66'(r_qx) + 66'(r_qy) + 66'(r_qz);
        r_hd3 <= r_hd2;
        r_s3_idx <= r_s2_idx;
    end

    localparam int unsigned TAG_W = AW + 21;
    logic              w_sq_vld;
    logic [32:0]       w_root;
    logic [TAG_W-1:0]  w_tag;
    nps_isqrt #(.TAG_W(TAG_W)) u_sqrt (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(r_s3_vld),
        .i_rad  (r_sum),
        .i_tag  ({r_s3_idx, r_hd3}),
        .o_valid(w_sq_vld),
        .o_root (w_root),
        .o_tag  (w_tag)
    );

    wire [35:0] w_cand_w = 36'(w_root) + 36'(w_tag[20:0]);
    wire [AW-1:0] w_cand_i = w_tag[TAG_W-1:21];

    // Tally thresholds: one product per pair of bins, all under 35 bits.
    logic [34:0] w_thr [5];
    always_comb begin
        for (int k = 0; k < 5; k++) begin
            w_thr[k] = 35'(r_thresh) * 35'(k + 1);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_acc && i_data.operation == OP_QUERY && r_len != '0)
                        n_state = S_SCAN;
            S_SCAN: if (w_sq_vld && r_seen + 1'b1 == r_len) n_state = S_DONE;
            S_DONE: n_state = S_OUT;
            S_OUT:  if (!r_out_vld) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Output register: every operation except a scanning query answers at once;
    // a scanning query answers from the best entry once the scan is done.
    always_comb begin
        n_out = r_out;
        if (w_acc) begin
            n_out = '0;
            unique case (i_data.operation)
                OP_APPEND: begin
                    if (w_we) n_out.nearest_index = 10'(r_len);
                    else      n_out.status = ST_FULL;
                end
                OP_QUERY: if (r_len == '0) n_out.status = ST_EMPTY;
                OP_READ: begin
                    if (i_data.tally_select <= SEL_MAX)
                        n_out.tally_value = r_tally[i_data.tally_select];
                    else
                        n_out.status = ST_BAD;
                end
                default: n_out.status = ST_BAD;
            endcase
        end else if (r_state == S_DONE) begin
            n_out.nearest_index     = r_best_idx;
            n_out.weighted_distance = r_best_w;
            n_out.absolute_distance = r_best_a;
        end
    end

    always_comb begin
        n_out_vld = r_out_vld;
        if (r_out_vld && i_ready) n_out_vld = 1'b0;
        if (w_acc && (i_data.operation != OP_QUERY || r_len == '0)) n_out_vld = 1'b1;
        if (r_state == S_DONE) n_out_vld = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_len     <= '0;
            r_out_vld <= 1'b0;
            r_rd_vld  <= 1'b0;
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            for (int k = 0; k < NUM_TALLY; k++) r_tally[k] <= '0;
        end else begin
            r_state   <= n_state;
            r_rd_vld  <= w_issue;
            r_s1_vld  <= r_rd_vld;
            r_s2_vld  <= r_s1_vld;
            r_s3_vld  <= r_s2_vld;
            r_out_vld <= n_out_vld;
            if (w_we) r_len <= r_len + 1'b1;
            if (r_state == S_DONE) begin
                for (int k = 0; k < 5; k++) begin
                    if (35'(r_best_a) > w_thr[k] && r_tally[k] != TALLY_MAX)
                        r_tally[k] <= r_tally[k] + 1'b1;
                    if (r_best_w > 36'(w_thr[k]) && r_tally[k+5] != TALLY_MAX)
                        r_tally[k+5] <= r_tally[k+5] + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_issue;
        if (w_acc) begin
            r_req    <= i_data;
            r_issue  <= '0;
            r_issued <= '0;
            r_seen   <= '0;
        end else if (w_issue) begin
            r_issue  <= r_issue + 1'b1;
            r_issued <= r_issued + 1'b1;
        end
        if (w_sq_vld && r_state == S_SCAN) begin
            r_seen <= r_seen + 1'b1;
            if (r_seen == '0 || w_cand_w < r_best_w) begin
                r_best_w   <= w_cand_w;
                r_best_a   <= 35'(w_root);
                r_best_idx <= 10'(w_cand_i);
            end
        end
        r_out <= n_out;
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

    // Never accept a beat while a result is pending.
    a_no_acc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> !o_ready) else $error("beat accepted while result pending");
    // The fill count never passes the store depth.
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LW'(ROUTE_DEPTH)) else $error("route length overflow");
    // A held result keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> $stable(o_data)) else $error("result changed");
endmodule
`default_nettype wire

// ===== tb/nps_checker.sv =====
// ----------------------------------------------------------------------------
// nps_checker
// Watches the item, result and configuration ports of the nearest pose search
// unit, keeps its own copy of the route store and tallies, predicts each
// result and compares it field by field with what the unit delivers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module nps_checker #(
    parameter int unsigned DEPTH = nps_pkg::ROUTE_DEPTH_DEF
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_in_valid,
    input  wire           i_in_ready,
    input  nps_pkg::t_in  i_in_data,
    input  wire           i_out_valid,
    input  wire           i_out_ready,
    input  nps_pkg::t_out i_out_data,
    input  wire           i_psel,
    input  wire           i_penable,
    input  wire           i_pwrite,
    input  wire           i_pready,
    input  wire [1:0]     i_paddr,
    input  wire [31:0]    i_pwdata,
    output int            o_pending,
    output int            o_failures
);
    import nps_pkg::*;

    logic signed [31:0] pose_x [DEPTH];
    logic signed [31:0] pose_y [DEPTH];
    logic signed [31:0] pose_z [DEPTH];
    logic [18:0]        pose_h [DEPTH];
    int unsigned        route_fill;
    logic [31:0]        exceed_count [NUM_TALLY];
    logic [31:0]        step_reg;
    t_out               awaited_q [$];
    int                 fail_count;

    assign o_pending  = awaited_q.size();
    assign o_failures = fail_count;

    function automatic logic [67:0] square_gap(logic signed [31:0] a, logic signed [31:0] b);
        logic signed [33:0] d;
        logic [67:0]        m;
        d = {{2{a[31]}}, a} - {{2{b[31]}}, b};
        if (d < 0) d = -d;
        m = 68'(d[32:0]);
        return m * m;
    endfunction

    function automatic logic [34:0] floor_root(logic [67:0] v);
        logic [67:0] r;
        logic [67:0] c;
        r = '0;
        for (int b = 32; b >= 0; b--) begin
            c = r | (68'd1 << b);
            if (c * c <= v) r = c;
        end
        return r[34:0];
    endfunction

    // Angles on opposite sides of pi are compared after lifting the lower one
    // by a full turn.
    function automatic logic [20:0] heading_gap(logic [18:0] a, logic [18:0] b);
        logic [20:0] x;
        logic [20:0] y;
        logic        ha;
        logic        hb;
        x  = 21'(a);
        y  = 21'(b);
        ha = a > PI_Q;
        hb = b > PI_Q;
        if (ha != hb) begin
            if (!ha) x = x + 21'(TWO_PI_Q);
            if (!hb) y = y + 21'(TWO_PI_Q);
        end
        return (x > y) ? x - y : y - x;
    endfunction

    function automatic t_out predict_pose_result(t_in d);
        t_out        r;
        logic [34:0] a;
        logic [35:0] w;
        logic [35:0] best_w;
        logic [34:0] best_a;
        logic [9:0]  best_i;
        logic [63:0] limit;
        r = '0;
        best_w = '0;
        best_a = '0;
        best_i = '0;
        case (d.operation)
            OP_APPEND: begin
                if (route_fill < DEPTH) begin
                    pose_x[route_fill] = d.coord_x;
                    pose_y[route_fill] = d.coord_y;
                    pose_z[route_fill] = d.coord_z;
                    pose_h[route_fill] = d.heading;
                    r.nearest_index = 10'(route_fill);
                    route_fill++;
                end else begin
                    r.status = ST_FULL;
                end
            end
            OP_QUERY: begin
                if (route_fill == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    for (int i = 0; i < route_fill; i++) begin
                        a = floor_root(square_gap(pose_x[i], d.coord_x)
                                     + square_gap(pose_y[i], d.coord_y)
                                     + square_gap(pose_z[i], d.coord_z));
                        w = 36'(a) + 36'({heading_gap(d.heading, pose_h[i]), 1'b0});
                        if (i == 0 || w < best_w) begin
                            best_w = w;
                            best_a = a;
                            best_i = 10'(i);
                        end
                    end
                    for (int k = 1; k <= 5; k++) begin
                        limit = 64'(step_reg) * 64'(k);
                        if (64'(best_a) > limit && exceed_count[k-1] != TALLY_MAX)
                            exceed_count[k-1]++;
                        if (64'(best_w) > limit && exceed_count[k+4] != TALLY_MAX)
                            exceed_count[k+4]++;
                    end
                    r.nearest_index     = best_i;
                    r.weighted_distance = best_w;
                    r.absolute_distance = best_a;
                end
            end
            OP_READ: begin
                if (d.tally_select <= SEL_MAX) r.tally_value = exceed_count[d.tally_select];
                else r.status = ST_BAD;
            end
            default: r.status = ST_BAD;
        endcase
        return r;
    endfunction

    task automatic report(string field, logic [63:0] got, logic [63:0] want);
        $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, field, got, want);
        fail_count++;
    endtask

    initial fail_count = 0;

    always @(posedge i_clk) begin
        t_out w;
        if (!i_rst_n) begin
            route_fill = 0;
            step_reg   = THRESH_RESET;
            for (int i = 0; i < NUM_TALLY; i++) exceed_count[i] = '0;
            awaited_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == ADDR_THRESH)
                step_reg = i_pwdata;
            if (i_out_valid && i_out_ready) begin
                if (awaited_q.size() == 0) begin
                    report("unexpected result beat", 64'(i_out_data), 64'd0);
                end else begin
                    w = awaited_q.pop_front();
                    if (i_out_data.nearest_index != w.nearest_index)
                        report("nearest_index", 64'(i_out_data.nearest_index),
                               64'(w.nearest_index));
                    if (i_out_data.weighted_distance != w.weighted_distance)
                        report("weighted_distance", 64'(i_out_data.weighted_distance),
                               64'(w.weighted_distance));
                    if (i_out_data.absolute_distance != w.absolute_distance)
                        report("absolute_distance", 64'(i_out_data.absolute_distance),
                               64'(w.absolute_distance));
                    if (i_out_data.tally_value != w.tally_value)
                        report("tally_value", 64'(i_out_data.tally_value), 64'(w.tally_value));
                    if (i_out_data.status != w.status)
                        report("status", 64'(i_out_data.status), 64'(w.status));
                end
            end
            if (i_in_valid && i_in_ready)
                awaited_q.insert(awaited_q.size(), predict_pose_result(i_in_data));
        end
    end
endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives the nearest pose search unit with directed and random pose beats,
// rewrites the threshold step between phases and reports the verdict given
// by the checker that sits beside the unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module testbench;
    import nps_pkg::*;

    localparam int unsigned DEPTH = ROUTE_DEPTH_DEF;
    localparam int RANDOM_BEATS = 500;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    t_in         in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_out        out_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          pending;
    int          failures;

    // Handshake between the stimulus and the result sink for the long hold.
    logic        hold_request = 1'b0;
    int          beat_no = 0;

    always #5 i_clk = ~i_clk;

    nearest_pose_search_unit #(.ROUTE_DEPTH(DEPTH)) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_valid),
        .o_ready (in_ready),
        .i_data  (in_data),
        .o_valid (out_valid),
        .i_ready (out_ready),
        .o_data  (out_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    nps_checker #(.DEPTH(DEPTH)) i_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_data  (out_data),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_pready    (pready),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .o_pending   (pending),
        .o_failures  (failures)
    );

    // Offers one beat and returns on the falling edge after it was taken.
    // The gap before it is drawn per beat; every 64 beats alternate between
    // gapped and back-to-back stretches. Valid is only lowered when a gap
    // follows, so it never drops and rises within one step.
    task automatic send_pose(t_in d);
        int gap;
        bit taken;
        gap = beat_no[6] ? 0 : $urandom_range(0, 13);
        beat_no++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= d;
        taken = 1'b0;
        while (!taken) begin
            #1;
            taken = in_ready;
            @(posedge i_clk);
            @(negedge i_clk);
        end
    endtask

    task automatic make_pose(output t_in d, input logic [1:0] op, input logic [31:0] x,
                             input logic [31:0] y, input logic [31:0] z, input logic [18:0] h,
                             input logic [3:0] sel);
        d.operation    = op;
        d.coord_x      = x;
        d.coord_y      = y;
        d.coord_z      = z;
        d.heading      = h;
        d.tally_select = sel;
    endtask

    // Mostly near the origin so that nearest entries are close contests,
    // with the full range and its corners mixed in.
    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 7))
            0, 1:    return $urandom;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            default: return 32'($urandom_range(0, 1 << 20)) - 32'(1 << 19);
        endcase
    endfunction

    function automatic logic [18:0] rand_heading();
        if ($urandom_range(0, 9) == 0) return 19'($urandom);
        return 19'($urandom_range(0, 411774));
    endfunction

    function automatic t_in rand_pose_beat();
        t_in d;
        int  pick;
        d.coord_x      = rand_coord();
        d.coord_y      = rand_coord();
        d.coord_z      = rand_coord();
        d.heading      = rand_heading();
        d.tally_select = ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'($urandom_range(0, 9));
        pick = $urandom_range(0, 99);
        if (pick < 30)      d.operation = OP_APPEND;
        else if (pick < 70) d.operation = OP_QUERY;
        else if (pick < 95) d.operation = OP_READ;
        else                d.operation = OP_RSVD;
        return d;
    endfunction

    // Threshold writes are made only with the unit drained; the pause covers
    // the fixed part of the query pipeline.
    task automatic write_step(logic [31:0] v);
        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (60) @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_THRESH;
        pwdata  <= v;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Result sink: a drawn stall per beat, back-to-back stretches, and one
    // long hold on request while the stimulus keeps offering beats.
    initial begin : result_sink
        int  gap;
        int  sunk;
        bit  taken;
        sunk = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                out_ready <= 1'b0;
                repeat (3000) @(negedge i_clk);
                hold_request = 1'b0;
            end
            gap = sunk[5] ? 0 : $urandom_range(0, 13);
            sunk++;
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            out_ready <= 1'b1;
            taken = 1'b0;
            while (!taken) begin
                #1;
                taken = out_valid;
                @(posedge i_clk);
                if (!taken) @(negedge i_clk);
            end
        end
    end

    initial begin : stimulus
        t_in d;
        logic [31:0] steps [5];
        steps = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd65536, 32'd0};
        steps[4] = $urandom;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: empty store, tally reads at and past the last bin,
        // the unknown operation, corner poses, heading on both sides of pi
        // and beyond a full turn, and a duplicate entry where the first wins.
        make_pose(d, OP_QUERY, 32'd0, 32'd0, 32'd0, 19'd0, 4'd0);          send_pose(d);
        make_pose(d, OP_READ, 32'd0, 32'd0, 32'd0, 19'd0, 4'd0);           send_pose(d);
        make_pose(d, OP_READ, 32'd0, 32'd0, 32'd0, 19'd0, 4'd9);           send_pose(d);
        make_pose(d, OP_READ, 32'd0, 32'd0, 32'd0, 19'd0, 4'd10);          send_pose(d);
        make_pose(d, OP_READ, 32'd0, 32'd0, 32'd0, 19'd0, 4'd15);          send_pose(d);
        make_pose(d, OP_RSVD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 19'h7FFFF, 4'hF);
        send_pose(d);
        make_pose(d, OP_APPEND, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 19'd0, 4'd0);
        send_pose(d);
        make_pose(d, OP_QUERY, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 19'd411774, 4'd0);
        send_pose(d);
        make_pose(d, OP_APPEND, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 19'd411774, 4'd0);
        send_pose(d);
        make_pose(d, OP_APPEND, 32'd0, 32'd0, 32'd0, 19'd205887, 4'd0);    send_pose(d);
        make_pose(d, OP_APPEND, 32'd0, 32'd0, 32'd0, 19'd205888, 4'd0);    send_pose(d);
        make_pose(d, OP_APPEND, 32'd65536, 32'd0, 32'd0, 19'd524287, 4'd0); send_pose(d);
        make_pose(d, OP_APPEND, 32'd65536, 32'd0, 32'd0, 19'd524287, 4'd0); send_pose(d);
        make_pose(d, OP_QUERY, 32'd0, 32'd0, 32'd0, 19'd205888, 4'd0);     send_pose(d);
        make_pose(d, OP_QUERY, 32'd0, 32'd0, 32'd0, 19'd1, 4'd0);          send_pose(d);
        make_pose(d, OP_QUERY, 32'd65536, 32'd0, 32'd0, 19'd524287, 4'd0); send_pose(d);
        make_pose(d, OP_QUERY, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 19'd411774, 4'd0);
        send_pose(d);
        for (int s = 0; s < NUM_TALLY; s++) begin
            make_pose(d, OP_READ, 32'd0, 32'd0, 32'd0, 19'd0, 4'(s));
            send_pose(d);
        end

        // Random phases, each under its own threshold step.
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n % 104 == 0) write_step(steps[n / 104]);
            if (n == 200) hold_request = 1'b1;
            if (n == 320) begin
                in_valid <= 1'b0;
                wait (pending == 0);
                @(negedge i_clk);
            end
            send_pose(rand_pose_beat());
        end

        // Finish with a few random beats, a query and a read of every tally.
        repeat (3) send_pose(rand_pose_beat());
        make_pose(d, OP_QUERY, rand_coord(), rand_coord(), rand_coord(), rand_heading(), 4'd0);
        send_pose(d);
        for (int s = 0; s < NUM_TALLY; s++) begin
            make_pose(d, OP_READ, 32'd0, 32'd0, 32'd0, 19'd0, 4'(s));
            send_pose(d);
        end
        in_valid <= 1'b0;

        wait (pending == 0);
        repeat (1200) @(negedge i_clk);
        if (failures == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin : watchdog
        #20_000_000;
        $display("Some tests failed");
        $finish;
    end
endmodule
`default_nettype wire
